// ----- src/rnc_pkg.sv -----
// Shared types, codes and channel conversion functions for the RGB/native color converter.
// No dependencies; used by rgb_native_color_converter.
package rnc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int PAL_W = 24;
  localparam int DIST_W = 18;
  localparam int CNT_W = 9;

  localparam logic [1:0] MODE_TO_NATIVE = 2'd0;
  localparam logic [1:0] MODE_TO_COLOR  = 2'd1;
  localparam logic [1:0] MODE_PAL_WRITE = 2'd2;

  localparam logic [1:0] CFG_PALETTE_COUNT = 2'd0;
  localparam logic [1:0] CFG_COLOR_SCHEME  = 2'd1;
  localparam logic [1:0] CFG_BIT_DEPTH     = 2'd2;

  localparam logic [7:0] SCHEME_NONE = 8'd0;
  localparam logic [7:0] SCHEME_332  = 8'd8;
  localparam logic [7:0] SCHEME_444  = 8'd12;
  localparam logic [7:0] SCHEME_555  = 8'd15;
  localparam logic [7:0] SCHEME_565  = 8'd16;
  localparam logic [7:0] SCHEME_666  = 8'd18;
  localparam logic [7:0] SCHEME_888  = 8'd24;

  localparam logic [5:0] DEPTH_RGB565 = 6'd16;

  localparam logic [31:0] NO_COLOR = 32'hffff_ffff;

  localparam int RecipShift = 24;
  localparam logic [22:0] RECIP_3  = 23'((2 ** RecipShift + 3 - 1) / 3);
  localparam logic [22:0] RECIP_7  = 23'((2 ** RecipShift + 7 - 1) / 7);
  localparam logic [22:0] RECIP_15 = 23'((2 ** RecipShift + 15 - 1) / 15);
  localparam logic [22:0] RECIP_31 = 23'((2 ** RecipShift + 31 - 1) / 31);
  localparam logic [22:0] RECIP_63 = 23'((2 ** RecipShift + 63 - 1) / 63);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } rnc_state_e;

  typedef struct packed {
    logic       known;
    logic [3:0] rb;
    logic [3:0] gb;
    logic [3:0] bb;
  } rnc_scheme_t;

  function automatic rnc_scheme_t scheme_decode(input logic [7:0] s);
    rnc_scheme_t d;
    d = '{known: 1'b1, rb: 4'd8, gb: 4'd8, bb: 4'd8};
    unique case (s)
      SCHEME_332: d = '{known: 1'b1, rb: 4'd3, gb: 4'd3, bb: 4'd2};
      SCHEME_444: d = '{known: 1'b1, rb: 4'd4, gb: 4'd4, bb: 4'd4};
      SCHEME_555: d = '{known: 1'b1, rb: 4'd5, gb: 4'd5, bb: 4'd5};
      SCHEME_565: d = '{known: 1'b1, rb: 4'd5, gb: 4'd6, bb: 4'd5};
      SCHEME_666: d = '{known: 1'b1, rb: 4'd6, gb: 4'd6, bb: 4'd6};
      SCHEME_888: d = '{known: 1'b1, rb: 4'd8, gb: 4'd8, bb: 4'd8};
      default:    d = '{known: 1'b0, rb: 4'd0, gb: 4'd0, bb: 4'd0};
    endcase
    return d;
  endfunction

  function automatic logic [8:0] live_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(PALETTE_ENTRIES);
    return (cnt > lim) ? lim : cnt;
  endfunction

  // round(v * top / 255), divide by 255 through shift-add
  function automatic logic [7:0] pack_chan(input logic [7:0] v, input logic [3:0] b);
    logic [15:0] x;
    logic [15:0] q;
    if (b >= 4'd8) begin
      return v;
    end
    x = (16'(v) << b) - 16'(v) + 16'd127;
    q = (x + 16'd1 + (x >> 8)) >> 8;
    return q[7:0];
  endfunction

  function automatic logic [22:0] recip(input logic [3:0] b);
    logic [22:0] m;
    case (b)
      4'd2:    m = RECIP_3;
      4'd3:    m = RECIP_7;
      4'd4:    m = RECIP_15;
      4'd5:    m = RECIP_31;
      default: m = RECIP_63;
    endcase
    return m;
  endfunction

  // round(v * 255 / top), divide by top through reciprocal multiply
  function automatic logic [7:0] expand_chan(input logic [7:0] v, input logic [3:0] b);
    logic [7:0]  top;
    logic [7:0]  vm;
    logic [15:0] x;
    logic [38:0] p;
    if (b >= 4'd8) begin
      return v;
    end
    top = 8'((9'd1 << b) - 9'd1);
    vm = v & top;
    x = (16'(vm) << 8) - 16'(vm) + 16'(top[7:1]);
    p = 39'(x) * 39'(recip(b));
    return p[RecipShift+7:RecipShift];
  endfunction

  function automatic logic [31:0] color_make(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    return {b, g, r, 8'h00};
  endfunction

  function automatic logic [31:0] native_direct(input logic [31:0] c, input logic [7:0] s,
                                                input logic [5:0] depth);
    rnc_scheme_t d;
    logic [7:0]  pr;
    logic [7:0]  pg;
    logic [7:0]  pb;
    d = scheme_decode(s);
    pr = pack_chan(c[15:8], d.rb);
    pg = pack_chan(c[23:16], d.gb);
    pb = pack_chan(c[31:24], d.bb);
    if (s != SCHEME_NONE) begin
      if (!d.known) begin
        return c;
      end
      return (32'(pr) << (5'(d.gb) + 5'(d.bb))) | (32'(pg) << d.bb) | 32'(pb);
    end
    if (depth == DEPTH_RGB565) begin
      if (c <= 32'h0000_ffff) begin
        return c;
      end
      return {16'h0000, c[15:11], c[23:18], c[31:27]};
    end
    return c;
  endfunction

  function automatic logic [31:0] color_direct(input logic [31:0] v, input logic [7:0] s,
                                               input logic [5:0] depth);
    rnc_scheme_t d;
    logic [31:0] vr;
    logic [31:0] vg;
    d = scheme_decode(s);
    vr = v >> (5'(d.gb) + 5'(d.bb));
    vg = v >> d.bb;
    if (s != SCHEME_NONE) begin
      if (!d.known) begin
        return v;
      end
      return color_make(expand_chan(vr[7:0], d.rb), expand_chan(vg[7:0], d.gb),
                        expand_chan(v[7:0], d.bb));
    end
    if (depth == DEPTH_RGB565) begin
      return color_make({v[15:11], v[15:13]}, {v[10:5], v[10:9]}, {v[4:0], v[4:2]});
    end
    return v;
  endfunction

endpackage

// ----- src/rnc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rgb_native_color_converter.sv -----
// Top level of the RGB/native color converter: palette RAM, nearest-color scan and direct packing.
// Depends on rnc_pkg and rnc_ram.

// A beat is accepted when start is high and busy is low; its result appears on result_o for
// one cycle with done_o high, in the cycle after the last cycle of work, and cannot be held off.
// Palette writes give no result. Direct conversions (no palette, or a native value at or
// beyond the palette count) are computed in the cycle that accepts the beat. A palette read for
// the reverse conversion waits in ST_READ for the registered RAM read data. The nearest-color
// search reads one palette entry per cycle from the palette RAM, up to the palette count (at most
// 256 entries), ending early on an exact match. Palette entries are undefined until written;
// there is no clearing pass after reset.
module rgb_native_color_converter
  import rnc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  palette_index_i,
  input  logic [23:0] palette_entry_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  rnc_state_e state_q, state_d;

  logic [CNT_W-1:0]  palette_count_q;
  logic [7:0]        color_scheme_q;
  logic [5:0]        bit_depth_q;
  logic [PAL_AW-1:0] idx_q, idx_d;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [PAL_AW-1:0] best_idx_q, best_idx_d;
  logic [PAL_W-1:0]  want_q, want_d;
  logic [31:0]       result_q, result_d;
  logic              done_q, done_d;

  logic              ram_we;
  logic [PAL_AW-1:0] ram_raddr;
  logic [PAL_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]  live;
  logic [7:0]        dr;
  logic [7:0]        dg;
  logic [7:0]        db;
  logic [DIST_W-1:0] sq_dist;
  logic              closer;
  logic              last;

  rnc_ram #(
    .WIDTH(PAL_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(palette_index_i[PAL_AW-1:0]),
    .wdata_i(palette_entry_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign live = live_count(palette_count_q);

  always_comb begin
    dr = (ram_rdata[23:16] > want_q[23:16]) ? ram_rdata[23:16] - want_q[23:16]
                                            : want_q[23:16] - ram_rdata[23:16];
    dg = (ram_rdata[15:8] > want_q[15:8]) ? ram_rdata[15:8] - want_q[15:8]
                                          : want_q[15:8] - ram_rdata[15:8];
    db = (ram_rdata[7:0] > want_q[7:0]) ? ram_rdata[7:0] - want_q[7:0]
                                        : want_q[7:0] - ram_rdata[7:0];
    sq_dist = DIST_W'(16'(dr) * 16'(dr)) + DIST_W'(16'(dg) * 16'(dg))
            + DIST_W'(16'(db) * 16'(db));
    closer = sq_dist < best_dist_q;
    last = (CNT_W'(idx_q) + CNT_W'(1)) == live;
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    best_dist_d = best_dist_q;
    best_idx_d = best_idx_q;
    want_d = want_q;
    result_d = result_q;
    done_d = 1'b0;
    ram_we = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_i)
            MODE_TO_NATIVE: begin
              if (value_i == NO_COLOR) begin
                result_d = '0;
                done_d = 1'b1;
              end else if (live != '0) begin
                want_d = {value_i[15:8], value_i[23:16], value_i[31:24]};
                idx_d = '0;
                best_dist_d = '1;
                best_idx_d = '0;
                state_d = ST_SCAN;
              end else begin
                result_d = native_direct(value_i, color_scheme_q, bit_depth_q);
                done_d = 1'b1;
              end
            end
            MODE_TO_COLOR: begin
              if (live != '0 && value_i < 32'(live)) begin
                ram_raddr = value_i[PAL_AW-1:0];
                state_d = ST_READ;
              end else begin
                result_d = color_direct(value_i, color_scheme_q, bit_depth_q);
                done_d = 1'b1;
              end
            end
            MODE_PAL_WRITE: ram_we = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_rdata == want_q) begin
          best_idx_d = idx_q;
          result_d = 32'(idx_q);
          done_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (closer) begin
            best_dist_d = sq_dist;
            best_idx_d = idx_q;
          end
          if (last) begin
            result_d = closer ? 32'(idx_q) : 32'(best_idx_q);
            done_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + PAL_AW'(1);
            ram_raddr = idx_q + PAL_AW'(1);
          end
        end
      end
      ST_READ: begin
        result_d = color_make(ram_rdata[23:16], ram_rdata[15:8], ram_rdata[7:0]);
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q <= 1'b0;
      idx_q <= '0;
      best_dist_q <= '1;
      best_idx_q <= '0;
      palette_count_q <= '0;
      color_scheme_q <= SCHEME_NONE;
      bit_depth_q <= DEPTH_RGB565;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      idx_q <= idx_d;
      best_dist_q <= best_dist_d;
      best_idx_q <= best_idx_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PALETTE_COUNT: palette_count_q <= cfg_data_i;
          CFG_COLOR_SCHEME:  color_scheme_q <= cfg_data_i[7:0];
          CFG_BIT_DEPTH:     bit_depth_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    want_q <= want_d;
    result_q <= result_d;
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign result_o = result_q;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for rgb_native_color_converter: conversion, palette-write and
// register-setting beats, each result checked against a bench-side color predictor.
// Depends on rnc_pkg and the converter RTL.
module tb;
  import rnc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] SCHEME_ODD  = 8'd7;
  localparam logic [7:0] SCHEME_TOP  = 8'd255;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [7:0] LEVELS [5] = '{8'h00, 8'h40, 8'h80, 8'hc0, 8'hff};

  class pixel_scoreboard;
    logic [23:0] pal [PALETTE_ENTRIES];
    logic [8:0]  pal_count;
    logic [7:0]  scheme;
    logic [5:0]  depth;
    logic [31:0] pending_results [$];
    int errors;
    int checked;

    function new();
      pal_count = '0;
      scheme = SCHEME_NONE;
      depth = DEPTH_RGB565;
      errors = 0;
      checked = 0;
      foreach (pal[i]) pal[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        CFG_PALETTE_COUNT: pal_count = data;
        CFG_COLOR_SCHEME:  scheme = data[7:0];
        CFG_BIT_DEPTH:     depth = data[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned live();
      return (pal_count > PALETTE_ENTRIES) ? PALETTE_ENTRIES : pal_count;
    endfunction

    function bit scheme_bits(logic [7:0] s, output int unsigned rb, gb, bb);
      rb = 8; gb = 8; bb = 8;
      case (s)
        SCHEME_332: begin rb = 3; gb = 3; bb = 2; end
        SCHEME_444: begin rb = 4; gb = 4; bb = 4; end
        SCHEME_555: begin rb = 5; gb = 5; bb = 5; end
        SCHEME_565: begin rb = 5; gb = 6; bb = 5; end
        SCHEME_666: begin rb = 6; gb = 6; bb = 6; end
        SCHEME_888: ;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function int unsigned shrink(int unsigned v, int unsigned bits);
      int unsigned top;
      if (bits >= 8) return v & 255;
      top = (1 << bits) - 1;
      return (v * top + 127) / 255;
    endfunction

    function int unsigned widen(int unsigned v, int unsigned bits);
      int unsigned top;
      if (bits >= 8) return v & 255;
      top = (1 << bits) - 1;
      return ((v & top) * 255 + top / 2) / top;
    endfunction

    function logic [31:0] native_of(logic [31:0] c);
      int unsigned r, g, b, n, want, e, rb, gb, bb, best_i;
      int dr, dg, db, d, best_d;
      r = c[15:8];
      g = c[23:16];
      b = c[31:24];
      if (c == NO_COLOR) return 32'd0;
      n = live();
      if (n != 0) begin
        want = b | (g << 8) | (r << 16);
        best_d = 'h3ffff;
        best_i = 0;
        for (int i = 0; i < n; i++) begin
          e = pal[i];
          if (e == want) begin
            best_i = i;
            break;
          end
          dr = int'((e >> 16) & 255) - int'(r);
          dg = int'((e >> 8) & 255) - int'(g);
          db = int'(e & 255) - int'(b);
          d = dr * dr + dg * dg + db * db;
          if (d < best_d) begin
            best_d = d;
            best_i = i;
          end
        end
        return best_i;
      end
      if (scheme != SCHEME_NONE) begin
        if (!scheme_bits(scheme, rb, gb, bb)) return c;
        return (shrink(r, rb) << (gb + bb)) | (shrink(g, gb) << bb) | shrink(b, bb);
      end
      if (depth == DEPTH_RGB565) begin
        if (c <= 32'h0000_ffff) return c;
        return ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
      end
      return c;
    endfunction

    function logic [31:0] color_of(logic [31:0] v);
      int unsigned n, rb, gb, bb;
      logic [23:0] e;
      logic [7:0] r8, g8, b8;
      n = live();
      if (n != 0 && v < n) begin
        e = pal[v[7:0]];
        return {e[7:0], e[15:8], e[23:16], 8'h00};
      end
      if (scheme != SCHEME_NONE) begin
        if (!scheme_bits(scheme, rb, gb, bb)) return v;
        r8 = 8'(widen(v >> (gb + bb), rb));
        g8 = 8'(widen(v >> bb, gb));
        b8 = 8'(widen(v, bb));
        return {b8, g8, r8, 8'h00};
      end
      if (depth == DEPTH_RGB565) begin
        return {v[4:0], v[4:2], v[10:5], v[10:9], v[15:11], v[15:13], 8'h00};
      end
      return v;
    endfunction

    function void note_beat(logic [1:0] m, logic [31:0] v, logic [7:0] ix, logic [23:0] en);
      case (m)
        MODE_TO_NATIVE: pending_results.push_back(native_of(v));
        MODE_TO_COLOR:  pending_results.push_back(color_of(v));
        MODE_PAL_WRITE: pal[ix] = en;
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] act);
      logic [31:0] want;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, act);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (act !== want) begin
        $display("%0t result mismatch: expected %h, actual %h", $time, want, act);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = '0;
  logic [31:0] value_i = '0;
  logic [7:0]  palette_index_i = '0;
  logic [23:0] palette_entry_i = '0;
  logic        done_o;
  logic [31:0] result_o;

  pixel_scoreboard board;
  int idle_pct = 34;
  int beats = 0;
  int settings = 0;
  int cycle_cnt = 0;
  bit written [PALETTE_ENTRIES];
  int filled = 0;

  rgb_native_color_converter u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start,
    .busy,
    .mode_i,
    .value_i,
    .palette_index_i,
    .palette_entry_i,
    .done_o,
    .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(result_o);
  end

  task automatic sender_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // hold the beat until it is taken, then record it
  task automatic send_beat(logic [1:0] m, logic [31:0] v, logic [7:0] ix, logic [23:0] en);
    start <= 1'b1;
    mode_i <= m;
    value_i <= v;
    palette_index_i <= ix;
    palette_entry_i <= en;
    do @(posedge clk_i); while (busy);
    board.note_beat(m, v, ix, en);
    if (m == MODE_PAL_WRITE) begin
      written[ix] = 1'b1;
      while (filled < PALETTE_ENTRIES && written[filled]) filled++;
    end
    beats++;
    sender_idle();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] ix, logic [8:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ix;
    cfg_data_i <= d;
    @(posedge clk_i);
    board.set_reg(ix, d);
  endtask

  task automatic apply_setting(logic [8:0] c, logic [7:0] s, logic [5:0] d);
    drain();
    cfg_write(CFG_PALETTE_COUNT, c);
    cfg_write(CFG_COLOR_SCHEME, {1'b0, s});
    cfg_write(CFG_BIT_DEPTH, {3'b000, d});
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [31:0] pick_color(int unsigned n);
    logic [23:0] e;
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(5))
      0: c = NO_COLOR;
      1: c = $urandom_range(32'h0000_ffff);
      2, 3: if (n != 0) begin
        e = board.pal[$urandom_range(n - 1)];
        c = {e[7:0], e[15:8], e[23:16], 8'($urandom)};
      end
      4: if (n != 0) begin
        e = board.pal[$urandom_range(n - 1)];
        c = {e[7:0] ^ 8'($urandom_range(7)), e[15:8] ^ 8'($urandom_range(7)),
             e[23:16] ^ 8'($urandom_range(7)), 8'($urandom)};
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic random_items(int k);
    int unsigned sel;
    int unsigned n;
    logic [31:0] v;
    for (int i = 0; i < k; i++) begin
      sel = $urandom_range(99);
      n = board.live();
      if ($urandom_range(40) == 0) drain();
      if (sel < 42) begin
        send_beat(MODE_TO_NATIVE, pick_color(n), 8'($urandom), 24'($urandom));
      end else if (sel < 84) begin
        case ($urandom_range(3))
          0: v = $urandom;
          1: v = $urandom_range(32'h0000_ffff);
          default: v = (n != 0) ? $urandom_range(n - 1) : $urandom_range(32'h0003_ffff);
        endcase
        send_beat(MODE_TO_COLOR, v, 8'($urandom), 24'($urandom));
      end else if (sel < 96) begin
        send_beat(MODE_PAL_WRITE, $urandom, 8'($urandom), 24'($urandom));
      end else begin
        send_beat(MODE_UNUSED, $urandom, 8'($urandom), 24'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic [8:0] c, logic [7:0] s, logic [5:0] d, int k);
    idle_pct = (settings < 8) ? 34 : (settings < 14) ? 64 : 0;
    apply_setting(c, s, d);
    random_items(k);
  endtask

  // entries from a coarse grid make distance ties likely
  task automatic fill_palette();
    logic [23:0] en;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      case ($urandom_range(3))
        0: en = (i > 0) ? board.pal[$urandom_range(i - 1)] : 24'($urandom);
        1: en = {LEVELS[$urandom_range(4)], LEVELS[$urandom_range(4)], LEVELS[$urandom_range(4)]};
        default: en = 24'($urandom);
      endcase
      send_beat(MODE_PAL_WRITE, $urandom, 8'(i), en);
    end
  endtask

  initial begin
    logic [7:0] odd_scheme;
    int unsigned rb, gb, bb;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(MODE_TO_NATIVE, NO_COLOR, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'h0000_0000, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'h0000_ffff, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'h0001_0000, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'hffff_fffe, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'h80c0_4000, 8'h00, 24'h000000);
    send_beat(MODE_TO_COLOR, 32'h0000_0000, 8'h00, 24'h000000);
    send_beat(MODE_TO_COLOR, 32'h0000_ffff, 8'h00, 24'h000000);
    send_beat(MODE_TO_COLOR, 32'hffff_ffff, 8'h00, 24'h000000);
    send_beat(MODE_UNUSED, 32'hffff_ffff, 8'hff, 24'hffffff);
    send_beat(MODE_PAL_WRITE, 32'h0000_0000, 8'd0, 24'h000000);
    send_beat(MODE_PAL_WRITE, 32'hffff_ffff, 8'd1, 24'hffffff);
    send_beat(MODE_PAL_WRITE, 32'h0000_0000, 8'd2, 24'h123456);
    send_beat(MODE_PAL_WRITE, 32'h0000_0000, 8'd3, 24'h8040c0);

    apply_setting(9'd4, SCHEME_NONE, DEPTH_RGB565);
    send_beat(MODE_TO_NATIVE, 32'h5634_12ab, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'hf0ff_fe00, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, NO_COLOR, 8'h00, 24'h000000);
    send_beat(MODE_TO_COLOR, 32'd3, 8'h00, 24'h000000);
    send_beat(MODE_TO_COLOR, 32'd4, 8'h00, 24'h000000);

    apply_setting(9'd0, SCHEME_888, 6'd1);
    send_beat(MODE_TO_COLOR, 32'hffff_ffff, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'hffff_ff00, 8'h00, 24'h000000);
    apply_setting(9'd0, SCHEME_332, 6'd32);
    send_beat(MODE_TO_COLOR, 32'hffff_ff00, 8'h00, 24'h000000);
    send_beat(MODE_TO_NATIVE, 32'h1234_5600, 8'h00, 24'h000000);
    apply_setting(9'd0, SCHEME_ODD, 6'd32);
    send_beat(MODE_TO_NATIVE, 32'hdead_beef, 8'h00, 24'h000000);
    send_beat(MODE_TO_COLOR, 32'hdead_beef, 8'h00, 24'h000000);

    run_phase(9'd0, SCHEME_NONE, DEPTH_RGB565, 12);
    run_phase(9'd0, SCHEME_NONE, 6'd1, 8);
    run_phase(9'd0, SCHEME_NONE, 6'd32, 8);
    run_phase(9'd0, SCHEME_332, DEPTH_RGB565, 10);
    run_phase(9'd0, SCHEME_444, 6'd5, 10);
    run_phase(9'd0, SCHEME_555, DEPTH_RGB565, 10);
    run_phase(9'd0, SCHEME_565, 6'd24, 10);
    run_phase(9'd0, SCHEME_666, DEPTH_RGB565, 10);
    run_phase(9'd0, SCHEME_888, DEPTH_RGB565, 10);
    run_phase(9'd0, SCHEME_TOP, DEPTH_RGB565, 6);
    do odd_scheme = 8'($urandom_range(1, 255));
    while (board.scheme_bits(odd_scheme, rb, gb, bb));
    run_phase(9'd0, odd_scheme, 6'($urandom_range(1, 32)), 6);

    fill_palette();

    run_phase(9'd1, SCHEME_565, DEPTH_RGB565, 12);
    run_phase(9'd2, SCHEME_NONE, DEPTH_RGB565, 12);
    run_phase(9'd17, SCHEME_565, DEPTH_RGB565, 16);
    run_phase(9'd256, SCHEME_NONE, DEPTH_RGB565, 10);
    run_phase(9'd511, SCHEME_444, 6'd1, 8);
    run_phase(9'd60, SCHEME_332, 6'd32, 16);
    run_phase(9'd0, SCHEME_NONE, DEPTH_RGB565, 10);

    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d beats over %0d register settings, %0d results checked",
             beats, settings, board.checked);
    $display("Settings spanned direct schemes, pass-through and palettes of 1 to 256 entries");
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
